// ===== hdl/brownian_tracer_reflect_step_defines.svh =====
// Assertion macros shared by the tracer RTL.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef BROWNIAN_TRACER_REFLECT_STEP_DEFINES_SVH
`define BROWNIAN_TRACER_REFLECT_STEP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BTRS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BTRS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/btrs_pkg.sv =====
package btrs_pkg;

	// Default geometry: 256x256 map, Q16.16 positions.
	localparam int GRID_BITS_DEF = 8;
	localparam int FRAC_BITS_DEF = 16;

	// Fixed field widths.
	localparam int POS_W     = 32;
	localparam int STEP_W    = 21;
	localparam int DIST_W    = 16;
	localparam int CELL_IN_W = 8;
	localparam int FUNC_W    = 2;
	localparam int OUTC_W    = 2;
	localparam int SQ_W      = 63;

	// Register port.
	localparam int DATA_W = 32;
	localparam int ADDR_W = 3;
	typedef logic [ADDR_W-3:0] reg_idx_t;
	localparam reg_idx_t REG_OPEN_THRESHOLD = '0;
	localparam logic [DIST_W-1:0] THRESH_RESET = 16'd13;

	// Saturation value of the squared displacement.
	localparam logic [SQ_W-1:0] SQ_SAT = '1;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_WRITE = 2'd0,
		FUNC_START = 2'd1,
		FUNC_STEP  = 2'd2,
		FUNC_NOP   = 2'd3
	} func_t;

	typedef enum logic [OUTC_W-1:0] {
		OUT_FREE    = 2'd0,
		OUT_REFLECT = 2'd1,
		OUT_REVERT  = 2'd2
	} outcome_t;

endpackage

// ===== hdl/btrs_cmd_if.sv =====
interface btrs_cmd_if;
	import btrs_pkg::*;

	logic                        valid;
	logic                        ready;
	logic [FUNC_W-1:0]           func;
	logic [CELL_IN_W-1:0]        cell_x;
	logic [CELL_IN_W-1:0]        cell_y;
	logic [DIST_W-1:0]           cell_value;
	logic signed [STEP_W-1:0]    step_x;
	logic signed [STEP_W-1:0]    step_y;

	modport source (output valid, func, cell_x, cell_y, cell_value, step_x, step_y,
		input ready);
	modport sink (input valid, func, cell_x, cell_y, cell_value, step_x, step_y,
		output ready);
endinterface

// ===== hdl/btrs_res_if.sv =====
interface btrs_res_if;
	import btrs_pkg::*;

	logic                        valid;
	logic                        ready;
	logic [SQ_W-1:0]             sq_displacement;
	logic signed [POS_W-1:0]     pos_x;
	logic signed [POS_W-1:0]     pos_y;
	logic                        start_blocked;
	logic [OUTC_W-1:0]           step_outcome;

	modport source (output valid, sq_displacement, pos_x, pos_y, start_blocked,
		step_outcome, input ready);
	modport sink (input valid, sq_displacement, pos_x, pos_y, start_blocked,
		step_outcome, output ready);
endinterface

// ===== hdl/btrs_ram.sv =====
module btrs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, two registered read ports; read data holds between reads.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

// ===== hdl/brownian_tracer_reflect_step.sv =====
// Brownian tracer stepping on a periodic distance map.
// Words arrive on cmd (valid/ready): func 0 loads one map cell, func 1 places the
// tracer and its origin on a cell center, func 2 takes one noisy step, func 3 does
// nothing. Every command word yields exactly one result word on res (valid/ready)
// carrying position, squared displacement, start-blocked flag and step outcome.
// The threshold register sits at byte address 0 of the APB-style port.
// A result passes through the stage 1 to 4 registers and the output register to res.
// Throughput: write, start and no-op words are taken one per cycle while res does not
// stall. For a step word, its new and mirrored cells are read together on the two read
// ports of the map RAM, and the next word waits until the position is resolved
// from that read data in stage 1.
// Reset clears the position, origin and pipeline and sets the threshold to 13; the map contents
// are undefined until written, and there is no clearing pass.
// When res stalls, results back up through the four pipeline stages; cmd stays
// ready until the stage behind the map read is full.
module brownian_tracer_reflect_step #(
	parameter int GRID_BITS = btrs_pkg::GRID_BITS_DEF,
	parameter int FRAC_BITS = btrs_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [btrs_pkg::ADDR_W-1:0]   paddr,
	input  logic [btrs_pkg::DATA_W-1:0]   pwdata,
	output logic [btrs_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	btrs_cmd_if.sink                      cmd,
	btrs_res_if.source                    res
);
	import btrs_pkg::*;
`include "brownian_tracer_reflect_step_defines.svh"

	localparam int MAP_AW    = 2 * GRID_BITS;
	localparam int MAP_DEPTH = 1 << MAP_AW;
	localparam int EXT_W     = POS_W + GRID_BITS;
	localparam int SQ_FULL_W = 2 * POS_W;
	localparam logic [POS_W-1:0] HALF_UNIT = POS_W'(1) << (FRAC_BITS - 1);

	// Cell index of a position that already has the half unit added.
	function automatic logic [GRID_BITS-1:0] cell_of_h(input logic [POS_W-1:0] h);
		logic [EXT_W-1:0] ext;
		ext = {{GRID_BITS{1'b0}}, h};
		return ext[FRAC_BITS +: GRID_BITS];
	endfunction

	// ------------------------------------------------------------------
	// Register port
	// ------------------------------------------------------------------
	logic [DIST_W-1:0] thr_q;
	logic              cfg_wr;
	reg_idx_t          reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THRESH_RESET;
		end else if (cfg_wr && (reg_idx == REG_OPEN_THRESHOLD)) begin
			thr_q <= pwdata[DIST_W-1:0];
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_OPEN_THRESHOLD: prdata = {{(DATA_W - DIST_W){1'b0}}, thr_q};
			default:            prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Pipeline handshake
	// ------------------------------------------------------------------
	logic valid_s1, valid_s2, valid_s3, valid_s4, res_valid_q;
	logic s1_rdy, s2_rdy, s3_rdy, s4_rdy, res_rdy;
	logic s1_is_step, cmd_acc;
	func_t func_s1;
	func_t cmd_func;

	assign res_rdy    = !res_valid_q || res.ready;
	assign s4_rdy     = !valid_s4 || res_rdy;
	assign s3_rdy     = !valid_s3 || s4_rdy;
	assign s2_rdy     = !valid_s2 || s3_rdy;
	assign s1_rdy     = !valid_s1 || s2_rdy;
	assign s1_is_step = valid_s1 && (func_s1 == FUNC_STEP);
	// A word behind a step waits until the step has resolved the position.
	assign cmd.ready  = s1_rdy && !s1_is_step;
	assign cmd_acc    = cmd.valid && cmd.ready;
	assign cmd_func   = func_t'(cmd.func);

	// ------------------------------------------------------------------
	// Accept stage: candidate positions and map addresses
	// ------------------------------------------------------------------
	logic [POS_W-1:0]     cur_q [2];
	logic [POS_W-1:0]     curh_q [2];
	logic [POS_W-1:0]     org_q [2];

	logic [POS_W-1:0]     sx [2];
	logic [POS_W-1:0]     mag [2];
	logic [POS_W-1:0]     npos [2];
	logic [POS_W-1:0]     nposh [2];
	logic [POS_W-1:0]     rpos [2];
	logic [POS_W-1:0]     rposh [2];
	logic [GRID_BITS-1:0] cell_new [2];
	logic [GRID_BITS-1:0] cell_old [2];
	logic [GRID_BITS-1:0] cell_ref [2];
	logic [GRID_BITS-1:0] cell_in [2];
	logic [POS_W-1:0]     start_pos [2];

	assign sx[0]      = {{(POS_W - STEP_W){cmd.step_x[STEP_W-1]}}, cmd.step_x};
	assign sx[1]      = {{(POS_W - STEP_W){cmd.step_y[STEP_W-1]}}, cmd.step_y};
	assign cell_in[0] = GRID_BITS'(cmd.cell_x);
	assign cell_in[1] = GRID_BITS'(cmd.cell_y);

	// Per axis: new position, and its mirror about the old position when the
	// cell index moved. Mirrors are formed in both domains so no add follows.
	always_comb begin
		for (int i = 0; i < 2; i++) begin
			mag[i]      = sx[i][POS_W-1] ? (POS_W'(0) - sx[i]) : sx[i];
			npos[i]     = cur_q[i] + sx[i];
			nposh[i]    = curh_q[i] + sx[i];
			cell_new[i] = cell_of_h(nposh[i]);
			cell_old[i] = cell_of_h(curh_q[i]);
			if (cell_new[i] < cell_old[i]) begin
				rpos[i]  = cur_q[i] + mag[i];
				rposh[i] = curh_q[i] + mag[i];
			end else if (cell_new[i] > cell_old[i]) begin
				rpos[i]  = cur_q[i] - mag[i];
				rposh[i] = curh_q[i] - mag[i];
			end else begin
				rpos[i]  = npos[i];
				rposh[i] = nposh[i];
			end
			cell_ref[i]  = cell_of_h(rposh[i]);
			start_pos[i] = POS_W'({cell_in[i], {FRAC_BITS{1'b0}}});
		end
	end

	// Distance map: port A reads the new cell (or the start cell), port B the
	// mirrored cell.
	logic              map_we, map_re;
	logic [MAP_AW-1:0] map_waddr, map_raddr_a, map_raddr_b;
	logic [DIST_W-1:0] map_rdata_a, map_rdata_b;

	assign map_we      = cmd_acc && (cmd_func == FUNC_WRITE);
	assign map_re      = cmd_acc;
	assign map_waddr   = {cell_in[0], cell_in[1]};
	assign map_raddr_a = (cmd_func == FUNC_STEP) ? {cell_new[0], cell_new[1]}
	                                             : {cell_in[0], cell_in[1]};
	assign map_raddr_b = {cell_ref[0], cell_ref[1]};

	btrs_ram #(
		.WIDTH (DIST_W),
		.DEPTH (MAP_DEPTH)
	) u_map (
		.clk     (clk),
		.we      (map_we),
		.waddr   (map_waddr),
		.wdata   (cmd.cell_value),
		.re      (map_re),
		.raddr_a (map_raddr_a),
		.raddr_b (map_raddr_b),
		.rdata_a (map_rdata_a),
		.rdata_b (map_rdata_b)
	);

	// Stage 1 registers.
	logic [POS_W-1:0] npos_s1 [2];
	logic [POS_W-1:0] nposh_s1 [2];
	logic [POS_W-1:0] rpos_s1 [2];
	logic [POS_W-1:0] rposh_s1 [2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			func_s1  <= FUNC_NOP;
		end else if (s1_rdy) begin
			valid_s1 <= cmd_acc;
			if (cmd_acc) begin
				func_s1 <= cmd_func;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			npos_s1  <= npos;
			nposh_s1 <= nposh;
			rpos_s1  <= rpos;
			rposh_s1 <= rposh;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: resolve the step from the map read data
	// ------------------------------------------------------------------
	logic             blk_new, blk_ref;
	outcome_t         s1_outcome;
	logic [POS_W-1:0] res_pos [2];
	logic [POS_W-1:0] res_posh [2];

	assign blk_new = (map_rdata_a <= thr_q);
	assign blk_ref = (map_rdata_b <= thr_q);

	always_comb begin
		s1_outcome = OUT_FREE;
		res_pos    = npos_s1;
		res_posh   = nposh_s1;
		if (blk_new && !blk_ref) begin
			s1_outcome = OUT_REFLECT;
			res_pos    = rpos_s1;
			res_posh   = rposh_s1;
		end else if (blk_new) begin
			s1_outcome = OUT_REVERT;
			res_pos    = cur_q;
			res_posh   = curh_q;
		end
	end

	// Tracer state: a step writes back when it leaves stage 1, a start when
	// it is accepted. The interlock keeps the two apart.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 2; i++) begin
				cur_q[i]  <= '0;
				curh_q[i] <= HALF_UNIT;
				org_q[i]  <= '0;
			end
		end else if (s1_is_step && s2_rdy) begin
			cur_q  <= res_pos;
			curh_q <= res_posh;
		end else if (cmd_acc && (cmd_func == FUNC_START)) begin
			for (int i = 0; i < 2; i++) begin
				cur_q[i]  <= start_pos[i];
				curh_q[i] <= start_pos[i] | HALF_UNIT;
				org_q[i]  <= start_pos[i];
			end
		end
	end

	// Stage 2 registers.
	logic             step_s2, sblk_s2;
	outcome_t         outcome_s2;
	logic [POS_W-1:0] pos_s2 [2];
	logic [POS_W-1:0] org_s2 [2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_rdy) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_rdy && valid_s1) begin
			step_s2    <= s1_is_step;
			sblk_s2    <= (func_s1 == FUNC_START) && (map_rdata_a == '0);
			outcome_s2 <= s1_is_step ? s1_outcome : OUT_FREE;
			pos_s2     <= s1_is_step ? res_pos : cur_q;
			org_s2     <= org_q;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: displacement magnitude per axis
	// ------------------------------------------------------------------
	logic [POS_W:0]   diff_po [2];
	logic [POS_W:0]   diff_op [2];
	logic [POS_W-1:0] dmag [2];

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			diff_po[i] = {pos_s2[i][POS_W-1], pos_s2[i]} - {org_s2[i][POS_W-1], org_s2[i]};
			diff_op[i] = {org_s2[i][POS_W-1], org_s2[i]} - {pos_s2[i][POS_W-1], pos_s2[i]};
			dmag[i]    = diff_po[i][POS_W] ? diff_op[i][POS_W-1:0] : diff_po[i][POS_W-1:0];
		end
	end

	// Stage 3 registers.
	logic             step_s3, sblk_s3;
	outcome_t         outcome_s3;
	logic [POS_W-1:0] pos_s3 [2];
	logic [POS_W-1:0] dmag_s3 [2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (s3_rdy) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (s3_rdy && valid_s2) begin
			step_s3    <= step_s2;
			sblk_s3    <= sblk_s2;
			outcome_s3 <= outcome_s2;
			pos_s3     <= pos_s2;
			dmag_s3    <= dmag;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: square each axis
	// ------------------------------------------------------------------
	logic                 step_s4, sblk_s4;
	outcome_t             outcome_s4;
	logic [POS_W-1:0]     pos_s4 [2];
	logic [SQ_FULL_W-1:0] sq_s4 [2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (s4_rdy) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (s4_rdy && valid_s3) begin
			step_s4    <= step_s3;
			sblk_s4    <= sblk_s3;
			outcome_s4 <= outcome_s3;
			pos_s4     <= pos_s3;
			for (int i = 0; i < 2; i++) begin
				sq_s4[i] <= SQ_FULL_W'(dmag_s3[i]) * SQ_FULL_W'(dmag_s3[i]);
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: sum with saturation, into the output register
	// ------------------------------------------------------------------
	logic [SQ_FULL_W:0] sq_sum;
	logic [SQ_W-1:0]    sq_out;

	assign sq_sum = {1'b0, sq_s4[0]} + {1'b0, sq_s4[1]};

	always_comb begin
		if (!step_s4) begin
			sq_out = '0;
		end else if (|sq_sum[SQ_FULL_W:SQ_W]) begin
			sq_out = SQ_SAT;
		end else begin
			sq_out = sq_sum[SQ_W-1:0];
		end
	end

	logic [SQ_W-1:0]  res_sq_q;
	logic [POS_W-1:0] res_pos_q [2];
	logic             res_sblk_q;
	outcome_t         res_outcome_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_rdy) begin
			res_valid_q <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (res_rdy && valid_s4) begin
			res_sq_q      <= sq_out;
			res_pos_q     <= pos_s4;
			res_sblk_q    <= sblk_s4;
			res_outcome_q <= outcome_s4;
		end
	end

	assign res.valid           = res_valid_q;
	assign res.sq_displacement = res_sq_q;
	assign res.pos_x           = res_pos_q[0];
	assign res.pos_y           = res_pos_q[1];
	assign res.start_blocked   = res_sblk_q;
	assign res.step_outcome    = res_outcome_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`BTRS_ASSERT_NEXT(a_step_enters_s1, cmd_acc && (cmd_func == FUNC_STEP),
		valid_s1 && (func_s1 == FUNC_STEP), "accepted step did not reach stage 1")
	`BTRS_ASSERT_NOW(a_step_interlock, s1_is_step, !cmd.ready,
		"command accepted while a step is resolving")
	`BTRS_ASSERT_NEXT(a_revert_holds, s1_is_step && s2_rdy && (s1_outcome == OUT_REVERT),
		$stable(cur_q[0]) && $stable(cur_q[1]), "reverted step moved the tracer")
	`BTRS_ASSERT_NOW(a_sblk_not_step, valid_s2 && sblk_s2,
		!step_s2 && (outcome_s2 == OUT_FREE), "start flag set on a step word")

endmodule
